>>> rtl/core/dfq_pkg.sv
// shared constants, codes and types of the duplicate-rejecting queue
package dfq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned ValW       = 31;
  localparam int unsigned InW        = 32;
  localparam int unsigned StatW      = 3;

  localparam logic [StatW-1:0] StOk        = 3'd0;
  localparam logic [StatW-1:0] StNegative  = 3'd1;
  localparam logic [StatW-1:0] StDuplicate = 3'd2;
  localparam logic [StatW-1:0] StFull      = 3'd3;
  localparam logic [StatW-1:0] StEmpty     = 3'd4;

  localparam logic CmdAppend = 1'b0;
  localparam logic CmdPop    = 1'b1;

  // per-cell control from the queue controller
  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> rtl/core/dfq_cell.sv
// one queue cell: holds a value, loads the key, compares it to the key, shifts toward the head
module dfq_cell (
  input  logic                     clk_i,
  input  dfq_pkg::cell_ctrl_t      ctrl_i,
  input  logic [dfq_pkg::ValW-1:0] key_i,
  input  logic [dfq_pkg::ValW-1:0] next_data_i,
  output logic [dfq_pkg::ValW-1:0] data_o,
  output logic                     match_o
);

  logic [dfq_pkg::ValW-1:0] data_q;
  logic [dfq_pkg::ValW-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = key_i;
    end else if (ctrl_i.shift) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = ctrl_i.occupied && (data_q == key_i);

endmodule

>>> rtl/core/dedup_fifo_queue_core.sv
// top level: fifo queue of non-negative values that rejects duplicates
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   command  | start_i / busy_o       | command_i, value_i
//   result   | result_valid_o strobe  | status_o, result_value_o
//
// one beat a cycle: every accepted command gives its registered result in the next cycle
// busy_o stays low, the cell row compares and shifts in the accepting cycle
// the cycle is set by the parallel compare of the key across all cells
// reset clears the entry count and the result strobe, the cells keep garbage
// the result receiver cannot stall, a result is shown for exactly one cycle
module dedup_fifo_queue_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            command_i,
  input  logic signed [dfq_pkg::InW-1:0]  value_i,
  output logic                            result_valid_o,
  output logic [dfq_pkg::StatW-1:0]       status_o,
  output logic [dfq_pkg::ValW-1:0]        result_value_o
);

  logic                                   accept;
  logic [dfq_pkg::ValW-1:0]               key;
  logic                                   negative;
  logic                                   duplicate;
  logic                                   full;
  logic                                   empty;
  logic                                   append_ok;
  logic                                   pop_ok;
  logic [dfq_pkg::QueueDepth-1:0]         match;
  logic [dfq_pkg::ValW-1:0]               cell_data [dfq_pkg::QueueDepth];
  dfq_pkg::cell_ctrl_t                    cell_ctrl [dfq_pkg::QueueDepth];

  logic [dfq_pkg::CntW-1:0]               count_q, count_d;
  logic                                   valid_q;
  logic [dfq_pkg::StatW-1:0]              status_q, status_d;
  logic [dfq_pkg::ValW-1:0]               result_q, result_d;

  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign key       = value_i[dfq_pkg::ValW-1:0];
  assign negative  = value_i[dfq_pkg::InW-1];
  assign duplicate = |match;
  assign full      = (count_q == dfq_pkg::CntW'(dfq_pkg::QueueDepth));
  assign empty     = (count_q == '0);

  always_comb begin
    status_d  = dfq_pkg::StOk;
    result_d  = '0;
    append_ok = 1'b0;
    pop_ok    = 1'b0;
    if (command_i == dfq_pkg::CmdAppend) begin
      if (negative) begin
        status_d = dfq_pkg::StNegative;
      end else if (duplicate) begin
        status_d = dfq_pkg::StDuplicate;
      end else if (full) begin
        status_d = dfq_pkg::StFull;
      end else begin
        append_ok = accept;
        result_d  = key;
      end
    end else begin
      if (empty) begin
        status_d = dfq_pkg::StEmpty;
      end else begin
        pop_ok   = accept;
        result_d = cell_data[0];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (append_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  // oldest value sits in cell 0, an appended value loads into the cell at index count
  for (genvar i = 0; i < dfq_pkg::QueueDepth; i++) begin : g_cell
    logic [dfq_pkg::ValW-1:0] next_data;

    if (i == dfq_pkg::QueueDepth - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    assign cell_ctrl[i].occupied = (dfq_pkg::CntW'(i) < count_q);
    assign cell_ctrl[i].load     = append_ok && (count_q == dfq_pkg::CntW'(i));
    assign cell_ctrl[i].shift    = pop_ok;

    dfq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .key_i      (key),
      .next_data_i(next_data),
      .data_o     (cell_data[i]),
      .match_o    (match[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dfq_pkg::CntW'(dfq_pkg::QueueDepth))
    else $error("entry count above queue depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without a command");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != dfq_pkg::StOk) |-> result_value_o == '0)
    else $error("rejected beat carries a value");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d == dfq_pkg::StOk) |=> count_q != $past(count_q))
    else $error("successful command left the count unchanged");

endmodule
